### hdl/ogru_pkg.sv
package ogru_pkg;

    // map geometry, grid size must be a power of two
    localparam int GRID_SIZE = 256;
    localparam int COORD_W   = $clog2(GRID_SIZE);
    localparam int ADDR_W    = 2 * COORD_W;
    localparam int FIELD_W   = 8;
    localparam int LO_W      = 16;
    localparam int ERR_W     = COORD_W + 3;
    localparam int E2_W      = ERR_W + 1;
    localparam int CMP_W     = COORD_W + FIELD_W;

    localparam logic [COORD_W-1:0] CENTRE = COORD_W'(GRID_SIZE / 2);

    // operation codes
    localparam logic [1:0] OP_BEAM = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_SCAN = 2'd2;

    // configuration register indexes
    localparam logic REG_OCC   = 1'b0;
    localparam logic REG_EMPTY = 1'b1;

    localparam logic signed [LO_W-1:0] OCC_RST   = 16'sd256;
    localparam logic signed [LO_W-1:0] EMPTY_RST = -16'sd128;

    typedef logic [COORD_W-1:0]      t_coord;
    typedef logic [ADDR_W-1:0]       t_addr;
    typedef logic signed [LO_W-1:0]  t_lo;
    typedef logic signed [ERR_W-1:0] t_err;

    function automatic t_coord clamp_coord(input logic [FIELD_W-1:0] v);
        logic [CMP_W-1:0] w;
        w = CMP_W'(v);
        if (w > CMP_W'(GRID_SIZE - 1)) begin
            w = CMP_W'(GRID_SIZE - 1);
        end
        return w[COORD_W-1:0];
    endfunction

    function automatic t_lo add_sat(input t_lo a, input t_lo b);
        logic signed [LO_W:0] s;
        s = {a[LO_W-1], a} + {b[LO_W-1], b};
        if (s[LO_W] != s[LO_W-1]) begin
            return s[LO_W] ? {1'b1, {(LO_W-1){1'b0}}} : {1'b0, {(LO_W-1){1'b1}}};
        end
        return s[LO_W-1:0];
    endfunction

endpackage

### hdl/occupancy_grid_ray_update.sv
// log-odds occupancy grid with ray update. a beam beat names the hit cell: that cell gets the
// occupied step and its hit mark, then a bresenham walk from the grid centre toward the hit cell
// (hit cell excluded) adds the empty step to every cell it crosses, all sums saturating to signed
// 16-bit q7.8. a read beat returns one cell's log-odds and hit mark, a new-scan beat clears the hit
// marks and keeps the log-odds. timing: the block takes one beat at a time. a beam's ray covers
// at most half the grid width in cells; the walker issues one memory read per cycle and the
// saturating add writes each cell back in the next cycle through the single write port. a read
// passes through a memory read state and an output state, waiting there while the result
// register is still full. a new scan sweeps the hit memory one entry a cycle. after reset the
// block clears both memories in the same way and takes no beat until done; configuration
// writes are taken at any time and are meant for idle periods only.
module occupancy_grid_ray_update
    import ogru_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input channel
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [1:0]               i_op,
    input  logic [FIELD_W-1:0]       i_cell_x,
    input  logic [FIELD_W-1:0]       i_cell_y,
    // result channel
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [LO_W-1:0]   o_cell_log_odds,
    output logic                     o_cell_hit,
    // configuration channel
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic                     i_cfg_index,
    input  logic [LO_W-1:0]          i_cfg_data
);

    // sequencer states
    localparam logic [2:0] S_CLR_ALL = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_HIT     = 3'd2;
    localparam logic [2:0] S_WALK    = 3'd3;
    localparam logic [2:0] S_DRAIN   = 3'd4;
    localparam logic [2:0] S_RD      = 3'd5;
    localparam logic [2:0] S_RD_OUT  = 3'd6;
    localparam logic [2:0] S_CLR_HIT = 3'd7;

    logic [2:0] r_state, n_state;
    t_addr      r_clr_cnt, n_clr_cnt;

    // configuration
    t_lo r_occ, r_empty;

    // latched target cell
    t_coord r_tx, r_ty;

    // walker
    t_coord r_wx, n_wx, r_wy, n_wy;
    t_err   r_err, n_err;
    t_coord r_dx, r_dy;       // dy kept as magnitude, used negated
    logic   r_sx, r_sy;

    // pending read-modify-write of one cell
    logic  r_pend, n_pend;
    logic  r_pend_occ, n_pend_occ;
    t_addr r_pend_addr, n_pend_addr;

    // result register
    logic r_out_valid;
    t_lo  r_out_lo;
    logic r_out_hit;
    logic out_load;

    // memories
    t_lo   lo_mem [GRID_SIZE*GRID_SIZE];
    logic  hit_mem [GRID_SIZE*GRID_SIZE];
    t_lo   r_lo_rd;
    logic  r_hit_rd;

    logic  lo_we, lo_re, hit_we, hit_re, hit_wdata;
    t_addr lo_waddr, lo_raddr, hit_waddr;
    t_lo   lo_wdata;

    // walker step terms
    logic signed [E2_W-1:0] e2, dx_e, dy_e, err_sum;
    logic   step_x, step_y, walk_at_tgt, walk_brk;
    t_addr  tgt_addr, walk_addr;

    logic in_acc;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;

    assign tgt_addr  = {r_ty, r_tx};
    assign walk_addr = {r_wy, r_wx};

    // bresenham decision for the current walker cell
    always_comb begin
        e2          = {r_err[ERR_W-1], r_err} <<< 1;
        dx_e        = $signed(E2_W'(r_dx));
        dy_e        = -$signed(E2_W'(r_dy));
        step_x      = (e2 >= dy_e);
        step_y      = (e2 <= dx_e);
        walk_at_tgt = (r_wx == r_tx) && (r_wy == r_ty);
        // the walk also ends if an axis would step past its target
        walk_brk    = (step_x && (r_wx == r_tx)) || (step_y && (r_wy == r_ty));
        err_sum     = {r_err[ERR_W-1], r_err} + (step_x ? dy_e : '0) + (step_y ? dx_e : '0);
    end

    always_comb begin
        n_state     = r_state;
        n_clr_cnt   = r_clr_cnt;
        n_wx        = r_wx;
        n_wy        = r_wy;
        n_err       = r_err;
        n_pend      = 1'b0;
        n_pend_occ  = 1'b0;
        n_pend_addr = r_pend_addr;
        out_load    = 1'b0;

        lo_re     = 1'b0;
        lo_raddr  = tgt_addr;
        hit_re    = 1'b0;
        hit_we    = 1'b0;
        hit_waddr = tgt_addr;
        hit_wdata = 1'b0;

        // write-back of the cell read in the previous cycle
        lo_we    = r_pend;
        lo_waddr = r_pend_addr;
        lo_wdata = add_sat(r_lo_rd, r_pend_occ ? r_occ : r_empty);

        unique case (r_state)
            S_CLR_ALL: begin
                lo_we     = 1'b1;
                lo_waddr  = r_clr_cnt;
                lo_wdata  = '0;
                hit_we    = 1'b1;
                hit_waddr = r_clr_cnt;
                n_clr_cnt = r_clr_cnt + 1'b1;
                if (&r_clr_cnt) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    case (i_op)
                        OP_BEAM: n_state = S_HIT;
                        OP_READ: n_state = S_RD;
                        OP_SCAN: begin
                            n_state   = S_CLR_HIT;
                            n_clr_cnt = '0;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_HIT: begin
                // read the hit cell, mark it, and start the walker at the centre
                lo_re       = 1'b1;
                hit_we      = 1'b1;
                hit_wdata   = 1'b1;
                n_pend      = 1'b1;
                n_pend_occ  = 1'b1;
                n_pend_addr = tgt_addr;
                n_wx        = CENTRE;
                n_wy        = CENTRE;
                n_err       = ERR_W'(r_tx > CENTRE ? r_tx - CENTRE : CENTRE - r_tx)
                            - ERR_W'(r_ty > CENTRE ? r_ty - CENTRE : CENTRE - r_ty);
                n_state     = S_WALK;
            end
            S_WALK: begin
                if (walk_at_tgt) begin
                    n_state = S_IDLE;
                end else begin
                    lo_re       = 1'b1;
                    lo_raddr    = walk_addr;
                    n_pend      = 1'b1;
                    n_pend_addr = walk_addr;
                    n_err       = err_sum[ERR_W-1:0];
                    if (step_x) begin
                        n_wx = r_sx ? r_wx + 1'b1 : r_wx - 1'b1;
                    end
                    if (step_y) begin
                        n_wy = r_sy ? r_wy + 1'b1 : r_wy - 1'b1;
                    end
                    if (walk_brk) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                n_state = S_IDLE;
            end
            S_RD: begin
                lo_re   = 1'b1;
                hit_re  = 1'b1;
                n_state = S_RD_OUT;
            end
            S_RD_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_CLR_HIT: begin
                hit_we    = 1'b1;
                hit_waddr = r_clr_cnt;
                n_clr_cnt = r_clr_cnt + 1'b1;
                if (&r_clr_cnt) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR_ALL;
            r_clr_cnt   <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_occ       <= OCC_RST;
            r_empty     <= EMPTY_RST;
        end else begin
            r_state   <= n_state;
            r_clr_cnt <= n_clr_cnt;
            r_pend    <= n_pend;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_OCC:   r_occ   <= i_cfg_data;
                    REG_EMPTY: r_empty <= i_cfg_data;
                    default:   r_occ   <= r_occ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_tx <= clamp_coord(i_cell_x);
            r_ty <= clamp_coord(i_cell_y);
        end
        if (r_state == S_HIT) begin
            r_dx <= (r_tx > CENTRE) ? r_tx - CENTRE : CENTRE - r_tx;
            r_dy <= (r_ty > CENTRE) ? r_ty - CENTRE : CENTRE - r_ty;
            r_sx <= (r_tx > CENTRE);
            r_sy <= (r_ty > CENTRE);
        end
        r_wx        <= n_wx;
        r_wy        <= n_wy;
        r_err       <= n_err;
        r_pend_occ  <= n_pend_occ;
        r_pend_addr <= n_pend_addr;
        if (out_load) begin
            r_out_lo  <= r_lo_rd;
            r_out_hit <= r_hit_rd;
        end
    end

    // log-odds memory
    always_ff @(posedge i_clk) begin
        if (lo_we) begin
            lo_mem[lo_waddr] <= lo_wdata;
        end
        if (lo_re) begin
            r_lo_rd <= lo_mem[lo_raddr];
        end
    end

    // hit mark memory
    always_ff @(posedge i_clk) begin
        if (hit_we) begin
            hit_mem[hit_waddr] <= hit_wdata;
        end
        if (hit_re) begin
            r_hit_rd <= hit_mem[tgt_addr];
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_cell_log_odds = r_out_lo;
    assign o_cell_hit      = r_out_hit;

    // no write-back may be in flight while idle or sweeping
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_CLR_ALL || r_state == S_CLR_HIT) |-> !r_pend)
        else $error("write-back pending outside a beam");

    // a cell is never read while it is being written back
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (lo_we && lo_re) |-> (lo_waddr != lo_raddr))
        else $error("read and write of the same cell in one cycle");

    // a read result never overwrites one still waiting
    a_out_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten");

    // a pending write-back always follows a read issued the cycle before
    a_pend_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> $past(lo_re))
        else $error("write-back without a read");

endmodule
